// ===== src/mtdu_pkg.sv =====
// ----------------------------------------------------------------------------
// mtdu_pkg
// Shared constants, types and helper functions of the MT19937 draw unit.
// ----------------------------------------------------------------------------
package mtdu_pkg;

  // twister geometry
  localparam int unsigned TW_N   = 624;
  localparam int unsigned TW_M   = 397;
  localparam int unsigned RAM_AW = $clog2(TW_N);
  localparam int unsigned IDX_W  = 10;

  localparam logic [31:0] TW_MATRIX    = 32'h9908_B0DF;
  localparam logic [31:0] TW_INIT_MULT = 32'd1812433253;
  localparam logic [31:0] SEED_RESET   = 32'd5489;
  localparam logic [31:0] TEMPER_B     = 32'h9D2C_5680;
  localparam logic [31:0] TEMPER_C     = 32'hEFC6_0000;

  localparam logic [RAM_AW-1:0] LAST_ADDR = RAM_AW'(TW_N - 1);
  localparam logic [IDX_W-1:0]  IDX_EMPTY = IDX_W'(TW_N);

  // uniform fraction: (hi >> 5) * 2^26 + (lo >> 6)
  localparam int unsigned UNIF_HI_SHIFT = 5;
  localparam int unsigned UNIF_LO_SHIFT = 6;
  localparam int unsigned UNIF_PAD      = 64 - (32 - UNIF_HI_SHIFT) - (32 - UNIF_LO_SHIFT);

  // configuration port
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned REGIDX_W = PADDR_W - 2;
  localparam logic [REGIDX_W-1:0] REG_SEED = '0;

  // request codes on the input channel
  localparam logic [1:0] OP_RAW  = 2'd0;
  localparam logic [1:0] OP_UNIF = 2'd1;
  localparam logic [1:0] OP_BND  = 2'd2;

  // queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    KIND_RAW,
    KIND_UNIF,
    KIND_BND,
    KIND_ZERO
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] offset;
    logic [31:0] bound;
    logic [31:0] mask;
  } draw_req_t;

  function automatic logic [31:0] tw_temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // all ones from the top set bit down
  function automatic logic [31:0] bound_mask(input logic [31:0] b);
    logic [31:0] m;
    m = b;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    m = m | (m >> 16);
    return m;
  endfunction

endpackage

// ===== src/mtdu_ram.sv =====
// ----------------------------------------------------------------------------
// mtdu_ram
// Generic single-write, dual-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mtdu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata0_r;
  logic [WIDTH-1:0] rdata1_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata0_r <= mem_r[raddr0];
    rdata1_r <= mem_r[raddr1];
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule

// ===== src/mtdu_front.sv =====
// ----------------------------------------------------------------------------
// mtdu_front
// Input stage: takes request beats, classifies them and builds the bound mask.
// ----------------------------------------------------------------------------
module mtdu_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_op,
  input  logic [31:0]         in_offset,
  input  logic [31:0]         in_upper_bound,
  output logic                push_valid,
  output mtdu_pkg::draw_req_t push_data,
  input  logic                push_full
);
  import mtdu_pkg::*;

  logic      stg_valid_r;
  logic      stg_valid_nxt;
  draw_req_t stg_data_r;
  draw_req_t req;
  logic      take;

  always_comb begin
    req.offset = in_offset;
    req.bound  = in_upper_bound;
    req.mask   = bound_mask(in_upper_bound);
    case (in_op)
      OP_RAW:  req.kind = KIND_RAW;
      OP_UNIF: req.kind = KIND_UNIF;
      OP_BND:  req.kind = (in_upper_bound == '0) ? KIND_ZERO : KIND_BND;
      default: req.kind = KIND_ZERO;
    endcase
  end

  assign in_ready   = !stg_valid_r || !push_full;
  assign take       = in_valid && in_ready;
  assign push_valid = stg_valid_r;
  assign push_data  = stg_data_r;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (take) begin
      stg_valid_nxt = 1'b1;
    end else if (stg_valid_r && !push_full) begin
      stg_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stg_data_r <= req;
    end
  end

endmodule

// ===== src/mtdu_fifo.sv =====
// ----------------------------------------------------------------------------
// mtdu_fifo
// Short request queue between the front and back of the draw unit.
// ----------------------------------------------------------------------------
module mtdu_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  input  mtdu_pkg::draw_req_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                q_valid,
  output mtdu_pkg::draw_req_t q_data
);
  import mtdu_pkg::*;

  draw_req_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QPTR_W:0]   count_r;
  logic [QPTR_W:0]   count_nxt;
  logic              push_en;
  logic              pop_en;

  assign full    = (count_r == (QPTR_W + 1)'(QDEPTH));
  assign q_valid = (count_r != '0);
  assign q_data  = mem_r[rd_ptr_r];
  assign push_en = push_valid && !full;
  assign pop_en  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push_en && !pop_en) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_en && !push_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/mtdu_back.sv =====
// ----------------------------------------------------------------------------
// mtdu_back
// Twister engine: seeding sweep, block regeneration, tempering and draws.
// ----------------------------------------------------------------------------
module mtdu_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                seed_wr,
  input  logic [31:0]         seed,
  input  logic                q_valid,
  input  mtdu_pkg::draw_req_t q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [63:0]         out_value
);
  import mtdu_pkg::*;

  typedef enum logic [3:0] {
    ST_INIT0,
    ST_INIT_MUL,
    ST_INIT_WR,
    ST_IDLE,
    ST_RG_START,
    ST_RG_PRIME,
    ST_RG_ISSUE,
    ST_RG_EXEC,
    ST_GET,
    ST_TEMP,
    ST_EVAL,
    ST_OUT
  } state_t;

  state_t            state_r;
  state_t            state_nxt;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  idx_nxt;
  logic [RAM_AW-1:0] k_r;
  logic [RAM_AW-1:0] k_nxt;
  logic [31:0]       p_r;
  logic [31:0]       p_nxt;
  logic [31:0]       prod_r;
  logic [31:0]       prod_nxt;
  draw_req_t         req_r;
  draw_req_t         req_nxt;
  logic              second_r;
  logic              second_nxt;
  logic [31:0]       hi_r;
  logic [31:0]       hi_nxt;
  logic [31:0]       word_r;
  logic [31:0]       word_nxt;
  logic [63:0]       res_r;
  logic [63:0]       res_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [63:0]       out_value_r;
  logic [63:0]       out_value_nxt;

  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [31:0]       ram_wdata;
  logic [RAM_AW-1:0] ram_raddr0;
  logic [RAM_AW-1:0] ram_raddr1;
  logic [31:0]       ram_rdata0;
  logic [31:0]       ram_rdata1;

  logic [RAM_AW:0]   far_sum;
  logic [RAM_AW-1:0] far_addr;
  logic [RAM_AW-1:0] next_addr;
  logic [31:0]       rg_y;
  logic [31:0]       rg_v;
  logic [31:0]       init_v;
  logic [31:0]       draw_d;

  mtdu_ram #(
    .WIDTH (32),
    .DEPTH (TW_N)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr0 (ram_raddr0),
    .raddr1 (ram_raddr1),
    .rdata0 (ram_rdata0),
    .rdata1 (ram_rdata1)
  );

  // k+397 and k+1 wrapped around the state array
  assign far_sum   = {1'b0, k_r} + (RAM_AW + 1)'(TW_M);
  assign far_addr  = (far_sum >= (RAM_AW + 1)'(TW_N)) ?
                     RAM_AW'(far_sum - (RAM_AW + 1)'(TW_N)) : far_sum[RAM_AW-1:0];
  assign next_addr = (k_r == LAST_ADDR) ? '0 : k_r + 1'b1;

  assign rg_y   = {p_r[31], ram_rdata1[30:0]};
  assign rg_v   = ram_rdata0 ^ (rg_y >> 1) ^ (rg_y[0] ? TW_MATRIX : '0);
  assign init_v = prod_r + 32'(k_r);
  assign draw_d = word_r & req_r.mask;

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    p_nxt         = p_r;
    prod_nxt      = prod_r;
    req_nxt       = req_r;
    second_nxt    = second_r;
    hi_nxt        = hi_r;
    word_nxt      = word_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    ram_we        = 1'b0;
    ram_waddr     = k_r;
    ram_wdata     = init_v;
    ram_raddr0    = k_r;
    ram_raddr1    = far_addr;
    q_pop         = 1'b0;

    case (state_r)
      ST_INIT0: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = seed;
        p_nxt     = seed;
        k_nxt     = RAM_AW'(1);
        idx_nxt   = IDX_EMPTY;
        state_nxt = ST_INIT_MUL;
      end
      ST_INIT_MUL: begin
        prod_nxt  = 32'(TW_INIT_MULT * (p_r ^ (p_r >> 30)));
        state_nxt = ST_INIT_WR;
      end
      ST_INIT_WR: begin
        ram_we = 1'b1;
        p_nxt  = init_v;
        if (k_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_INIT_MUL;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          req_nxt    = q_data;
          second_nxt = 1'b0;
          if (q_data.kind == KIND_ZERO) begin
            res_nxt   = '0;
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_GET;
          end
        end
      end
      ST_RG_START: begin
        ram_raddr0 = '0;
        k_nxt      = '0;
        state_nxt  = ST_RG_PRIME;
      end
      ST_RG_PRIME: begin
        p_nxt     = ram_rdata0;
        state_nxt = ST_RG_ISSUE;
      end
      ST_RG_ISSUE: begin
        // port 0 fetches mt[k+397], port 1 fetches mt[k+1]
        ram_raddr0 = far_addr;
        ram_raddr1 = next_addr;
        state_nxt  = ST_RG_EXEC;
      end
      ST_RG_EXEC: begin
        ram_we    = 1'b1;
        ram_wdata = rg_v;
        p_nxt     = ram_rdata1;
        if (k_r == LAST_ADDR) begin
          idx_nxt   = '0;
          state_nxt = ST_GET;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_RG_ISSUE;
        end
      end
      ST_GET: begin
        if (idx_r == IDX_EMPTY) begin
          state_nxt = ST_RG_START;
        end else begin
          ram_raddr0 = RAM_AW'(idx_r);
          state_nxt  = ST_TEMP;
        end
      end
      ST_TEMP: begin
        word_nxt  = tw_temper(ram_rdata0);
        idx_nxt   = idx_r + 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        case (req_r.kind)
          KIND_RAW, KIND_UNIF: begin
            if (!second_r) begin
              hi_nxt     = word_r;
              second_nxt = 1'b1;
              state_nxt  = ST_GET;
            end else begin
              if (req_r.kind == KIND_RAW) begin
                res_nxt = {hi_r, word_r};
              end else begin
                res_nxt = {{UNIF_PAD{1'b0}}, hi_r[31:UNIF_HI_SHIFT],
                           word_r[31:UNIF_LO_SHIFT]};
              end
              state_nxt = ST_OUT;
            end
          end
          KIND_BND: begin
            // reject draws above range and fetch another word
            if (draw_d <= req_r.bound) begin
              res_nxt   = 64'(req_r.offset) + 64'(draw_d);
              state_nxt = ST_OUT;
            end else begin
              state_nxt = ST_GET;
            end
          end
          default: begin
            res_nxt   = '0;
            state_nxt = ST_OUT;
          end
        endcase
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT0;
      end
    endcase

    if (seed_wr) begin
      state_nxt = ST_INIT0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT0;
      idx_r       <= IDX_EMPTY;
      k_r         <= '0;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      k_r         <= k_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
    end
    p_r         <= p_nxt;
    prod_r      <= prod_nxt;
    req_r       <= req_nxt;
    hi_r        <= hi_nxt;
    word_r      <= word_nxt;
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
  end

endmodule

// ===== src/mt19937_draw_unit_top.sv =====
// ----------------------------------------------------------------------------
// mt19937_draw_unit_top
// MT19937 draw unit: raw 64-bit, 53-bit fraction and bounded integer draws.
// path: front stage register, request queue, engine; the engine reads, tempers and
// evaluates one twister word at a time; raw/uniform use two words, bounded draws
// retry above range; zero range/unused selector give zero; one request at a time
// every 624 words the engine regenerates the state ram
// reset or a seed write runs the seeding sweep (multiply loop)
// requests queue up during the sweep; they are served once it finishes
// ----------------------------------------------------------------------------
module mt19937_draw_unit_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_op,
  input  logic [31:0]                 in_offset,
  input  logic [31:0]                 in_upper_bound,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [63:0]                 out_value,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mtdu_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import mtdu_pkg::*;

  logic              push_valid;
  draw_req_t         push_data;
  logic              q_full;
  logic              q_valid;
  draw_req_t         q_data;
  logic              q_pop;
  logic [31:0]       seed_r;
  logic [31:0]       seed_nxt;
  logic              seed_wr;
  logic [REGIDX_W-1:0] reg_idx;

  // register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign seed_wr = psel && penable && pwrite && (reg_idx == REG_SEED);
  assign prdata  = (reg_idx == REG_SEED) ? seed_r : '0;
  assign seed_nxt = seed_wr ? pwdata : seed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else begin
      seed_r <= seed_nxt;
    end
  end

  mtdu_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_offset      (in_offset),
    .in_upper_bound (in_upper_bound),
    .push_valid     (push_valid),
    .push_data      (push_data),
    .push_full      (q_full)
  );

  mtdu_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (q_pop),
    .q_valid    (q_valid),
    .q_data     (q_data)
  );

  mtdu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .seed_wr   (seed_wr),
    .seed      (seed_r),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value)
  );

`ifndef ASSERT_OFF
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("engine popped an empty request queue");

  a_full_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> q_valid)
    else $error("request queue full but reports no data");

  a_seed_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    seed_wr |=> !q_pop)
    else $error("request taken right after a seed write");
`endif

endmodule
